>>> rtl/tbs_pkg.sv
// Shared types, constants and fixed-point helpers of the two-bone skinning unit.
// Depends on nothing; tbs_bone, the top level and the testbench import it.
package tbs_pkg;

  localparam int WORDS_PER_BONE = 12;
  localparam int BONES_DEFAULT = 512;
  localparam logic [15:0] MARGIN_RESET = 16'd66;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  typedef logic signed [31:0] word_t;
  typedef logic signed [15:0] half_t;
  typedef word_t mat_t [WORDS_PER_BONE];
  typedef word_t vec32_t [3];
  typedef half_t vec16_t [3];

  // Rounds a Q.32 style product back by sixteen bits, floor after adding one half.
  function automatic logic signed [63:0] round16(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd32768;
    return t >>> 16;
  endfunction

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic half_t sat16(input logic signed [63:0] v);
    half_t r;
    if (v > 64'sh0000_0000_0000_7FFF) begin
      r = 16'sh7FFF;
    end else if (v < -64'sh0000_0000_0000_8000) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/tbs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module tbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/tbs_bone.sv
// Two-stage transform of one vertex by one bone matrix: products, then rounded row sums.
// Depends on tbs_pkg.
module tbs_bone
  import tbs_pkg::*;
(
  input  logic   clk_i,
  input  logic   en_i,
  input  mat_t   mat_i,
  input  vec32_t pos_i,
  input  vec16_t norm_i,
  output vec32_t pos_o,
  output vec16_t norm_o
);

  logic signed [63:0] pprod_q [9];
  logic signed [47:0] nprod_q [9];
  word_t              trans_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        trans_q[r] <= mat_i[9 + r];
        for (int c = 0; c < 3; c++) begin
          pprod_q[r*3 + c] <= mat_i[r*3 + c] * pos_i[c];
          nprod_q[r*3 + c] <= mat_i[r*3 + c] * norm_i[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        pos_o[r] <= sat32(64'(trans_q[r]) + round16(pprod_q[r*3]) +
                          round16(pprod_q[r*3 + 1]) + round16(pprod_q[r*3 + 2]));
        norm_o[r] <= sat16(round16(64'(nprod_q[r*3]) + 64'(nprod_q[r*3 + 1]) +
                                   64'(nprod_q[r*3 + 2])));
      end
    end
  end

endmodule

>>> rtl/two_bone_vertex_skinning_unit.sv
// Top level of the two-bone linear blend skinning unit.
// Depends on tbs_pkg, tbs_ram and tbs_bone.
//
// Input channel (in_valid_i / in_ready_o): each item is either a load of one
// matrix word (action_i high) or a vertex. Loads with bone_a_i and word_index_i
// in range write one 32-bit word of the bone table and give no result. Vertices
// give one result item on the output channel (out_valid_o / out_ready_i), in order.
// The configuration channel writes weight_margin; it is always ready.
// Throughput is one item per cycle while the receiver does not stall. A vertex
// result is formed in order: the table is read at the accepting edge, then come
// the per-bone products and row sums, the blend product and the output register.
// The table is two copies of twelve word banks, one copy read by bone_a and
// one by bone_b, so both bones are read together.
// A load followed at once by a vertex of the same bone sees the new word.
// Reset empties the pipeline and sets weight_margin to 66; table contents are
// undefined until loaded. When the receiver stalls, the whole pipeline holds
// and in_ready_o drops until the output item is taken.
module two_bone_vertex_skinning_unit
  import tbs_pkg::*;
#(
  parameter int BONES = BONES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [8:0]         bone_a_i,
  input  logic [8:0]         bone_b_i,
  input  logic [16:0]        weight_a_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  input  logic [3:0]         word_index_i,
  input  logic signed [31:0] word_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_pos_z_o,
  output logic signed [15:0] out_norm_x_o,
  output logic signed [15:0] out_norm_y_o,
  output logic signed [15:0] out_norm_z_o
);

  localparam int AW = $clog2(BONES);
  localparam int XW = (AW > 9) ? AW : 9;

  typedef enum logic [1:0] {
    MODE_A,
    MODE_B,
    MODE_MIX
  } mode_e;

  logic          en;
  logic          accept;
  logic          we;
  logic [15:0]   margin_q;
  logic [XW-1:0] ba_x;
  logic [XW-1:0] bb_x;
  logic          ba_ok;
  logic          bb_ok;
  mode_e         mode_d;

  logic   v1_q, v2_q, v3_q, v4_q;
  mode_e  mode1_q, mode2_q, mode3_q;
  logic [16:0] w1_q, w2_q, w3_q;
  logic   aok1_q, bok1_q;
  vec32_t pos1_q;
  vec16_t norm1_q;
  word_t  rd_a [WORDS_PER_BONE];
  word_t  rd_b [WORDS_PER_BONE];
  mat_t   mat_a;
  mat_t   mat_b;
  vec32_t bpos_a, bpos_b;
  vec16_t bnorm_a, bnorm_b;

  word_t               base_pos4_q [3];
  half_t               base_norm4_q [3];
  logic signed [50:0]  dpos4_q [3];
  logic signed [34:0]  dnorm4_q [3];
  logic signed [17:0]  w3s;
  logic signed [32:0]  dp [3];
  logic signed [16:0]  dn [3];

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  assign ba_x  = XW'(bone_a_i);
  assign bb_x  = XW'(bone_b_i);
  assign ba_ok = 32'(bone_a_i) < 32'(BONES);
  assign bb_ok = 32'(bone_b_i) < 32'(BONES);
  assign we    = accept && action_i && ba_ok && (32'(word_index_i) < 32'(WORDS_PER_BONE));

  always_comb begin
    if ({1'b0, weight_a_i} >= 18'(WEIGHT_ONE) - 18'(margin_q)) begin
      mode_d = MODE_A;
    end else if (weight_a_i <= 17'(margin_q)) begin
      mode_d = MODE_B;
    end else begin
      mode_d = MODE_MIX;
    end
  end

  for (genvar k = 0; k < WORDS_PER_BONE; k++) begin : g_bank
    tbs_ram #(.Width(32), .Depth(BONES)) u_ram_a (
      .clk_i  (clk_i),
      .we_i   (we && (word_index_i == 4'(k))),
      .waddr_i(ba_x[AW-1:0]),
      .wdata_i(word_value_i),
      .re_i   (en),
      .raddr_i(ba_x[AW-1:0]),
      .rdata_o(rd_a[k])
    );
    tbs_ram #(.Width(32), .Depth(BONES)) u_ram_b (
      .clk_i  (clk_i),
      .we_i   (we && (word_index_i == 4'(k))),
      .waddr_i(ba_x[AW-1:0]),
      .wdata_i(word_value_i),
      .re_i   (en),
      .raddr_i(bb_x[AW-1:0]),
      .rdata_o(rd_b[k])
    );
    assign mat_a[k] = aok1_q ? rd_a[k] : '0;
    assign mat_b[k] = bok1_q ? rd_b[k] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      margin_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q        <= accept && !action_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode1_q    <= mode_d;
      w1_q       <= weight_a_i;
      aok1_q     <= ba_ok;
      bok1_q     <= bb_ok;
      pos1_q[0]  <= pos_x_i;
      pos1_q[1]  <= pos_y_i;
      pos1_q[2]  <= pos_z_i;
      norm1_q[0] <= norm_x_i;
      norm1_q[1] <= norm_y_i;
      norm1_q[2] <= norm_z_i;
      mode2_q    <= mode1_q;
      w2_q       <= w1_q;
      mode3_q    <= mode2_q;
      w3_q       <= w2_q;
    end
  end

  tbs_bone u_bone_a (
    .clk_i (clk_i),
    .en_i  (en),
    .mat_i (mat_a),
    .pos_i (pos1_q),
    .norm_i(norm1_q),
    .pos_o (bpos_a),
    .norm_o(bnorm_a)
  );

  tbs_bone u_bone_b (
    .clk_i (clk_i),
    .en_i  (en),
    .mat_i (mat_b),
    .pos_i (pos1_q),
    .norm_i(norm1_q),
    .pos_o (bpos_b),
    .norm_o(bnorm_b)
  );

  assign w3s = (mode3_q == MODE_MIX) ? $signed({1'b0, w3_q}) : 18'sd0;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dp[r] = 33'(bpos_a[r]) - 33'(bpos_b[r]);
      dn[r] = 17'(bnorm_a[r]) - 17'(bnorm_b[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        base_pos4_q[r]  <= (mode3_q == MODE_A) ? bpos_a[r] : bpos_b[r];
        base_norm4_q[r] <= (mode3_q == MODE_A) ? bnorm_a[r] : bnorm_b[r];
        dpos4_q[r]      <= dp[r] * w3s;
        dnorm4_q[r]     <= dn[r] * w3s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pos_x_o  <= 32'(64'(base_pos4_q[0]) + round16(64'(dpos4_q[0])));
      out_pos_y_o  <= 32'(64'(base_pos4_q[1]) + round16(64'(dpos4_q[1])));
      out_pos_z_o  <= 32'(64'(base_pos4_q[2]) + round16(64'(dpos4_q[2])));
      out_norm_x_o <= 16'(64'(base_norm4_q[0]) + round16(64'(dnorm4_q[0])));
      out_norm_y_o <= 16'(64'(base_norm4_q[1]) + round16(64'(dnorm4_q[1])));
      out_norm_z_o <= 16'(64'(base_norm4_q[2]) + round16(64'(dnorm4_q[2])));
    end
  end

  a_write_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (in_valid_i && in_ready_o && action_i))
    else $error("table written without an accepted load item");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v1_q) && $stable(v2_q) && $stable(v3_q) && $stable(v4_q)))
    else $error("pipeline moved while stalled");

  a_out_from_stage4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v4_q))
    else $error("result item without a vertex in the blend stage");

  a_single_bone_no_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v3_q && (mode3_q != MODE_MIX)) |=> (dpos4_q[0] == '0 && dnorm4_q[0] == '0))
    else $error("blend term nonzero for a single-bone vertex");

endmodule

>>> verif/tb_two_bone_vertex_skinning_unit.sv
// Testbench of the two-bone vertex skinning unit: directed table, then random phases.
// Depends on rtl/tbs_pkg.sv and rtl/two_bone_vertex_skinning_unit.sv; checks against its own predictor.
`timescale 1ns / 1ps
module tb_two_bone_vertex_skinning_unit;
  import tbs_pkg::*;

  localparam int NBONES = BONES_DEFAULT;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic        action;
    logic [8:0]  bone_a;
    logic [8:0]  bone_b;
    logic [16:0] weight;
    word_t       px, py, pz;
    half_t       nx, ny, nz;
    logic [3:0]  widx;
    word_t       wval;
  } vtx_item_t;

  typedef struct {
    word_t px, py, pz;
    half_t nx, ny, nz;
  } skinned_t;

  typedef struct {
    vtx_item_t item;
    bit        typed;
    skinned_t  res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic action_i = 1'b0;
  logic [8:0] bone_a_i = '0;
  logic [8:0] bone_b_i = '0;
  logic [16:0] weight_a_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] norm_x_i = '0, norm_y_i = '0, norm_z_i = '0;
  logic [3:0] word_index_i = '0;
  logic signed [31:0] word_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic signed [15:0] out_norm_x_o, out_norm_y_o, out_norm_z_o;

  two_bone_vertex_skinning_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .action_i(action_i), .bone_a_i(bone_a_i), .bone_b_i(bone_b_i),
    .weight_a_i(weight_a_i),
    .pos_x_i(pos_x_i), .pos_y_i(pos_y_i), .pos_z_i(pos_z_i),
    .norm_x_i(norm_x_i), .norm_y_i(norm_y_i), .norm_z_i(norm_z_i),
    .word_index_i(word_index_i), .word_value_i(word_value_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_pos_x_o(out_pos_x_o), .out_pos_y_o(out_pos_y_o), .out_pos_z_o(out_pos_z_o),
    .out_norm_x_o(out_norm_x_o), .out_norm_y_o(out_norm_y_o), .out_norm_z_o(out_norm_z_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  word_t bone_words [NBONES][WORDS_PER_BONE];
  bit word_loaded [NBONES][WORDS_PER_BONE];
  int loaded_bones [$];
  int bone_pool [$];
  logic [15:0] snap_margin = MARGIN_RESET;
  skinned_t skinned_q [$];
  int mismatches = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  function automatic longint rnd16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint blend_toward(longint a, longint b, longint w);
    return b + rnd16((a - b) * w);
  endfunction

  function automatic bit same_result(skinned_t a, skinned_t b);
    return a.px === b.px && a.py === b.py && a.pz === b.pz &&
           a.nx === b.nx && a.ny === b.ny && a.nz === b.nz;
  endfunction

  function automatic skinned_t one_bone_xform(int b, vtx_item_t it);
    skinned_t r;
    longint p [3];
    longint n [3];
    longint ps, ns, m;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    n[0] = it.nx; n[1] = it.ny; n[2] = it.nz;
    for (int row = 0; row < 3; row++) begin
      ps = bone_words[b][9 + row];
      ns = 0;
      for (int c = 0; c < 3; c++) begin
        m = bone_words[b][row * 3 + c];
        ps += rnd16(m * p[c]);
        ns += m * n[c];
      end
      ps = clamp(ps, 32);
      ns = clamp(rnd16(ns), 16);
      case (row)
        0: begin r.px = 32'(ps); r.nx = 16'(ns); end
        1: begin r.py = 32'(ps); r.ny = 16'(ns); end
        default: begin r.pz = 32'(ps); r.nz = 16'(ns); end
      endcase
    end
    return r;
  endfunction

  function automatic skinned_t skin_vertex(vtx_item_t it);
    skinned_t ra, rb, r;
    longint w;
    w = it.weight;
    if (w >= 65536 - longint'(snap_margin)) return one_bone_xform(it.bone_a, it);
    if (w <= longint'(snap_margin)) return one_bone_xform(it.bone_b, it);
    ra = one_bone_xform(it.bone_a, it);
    rb = one_bone_xform(it.bone_b, it);
    r.px = 32'(blend_toward(ra.px, rb.px, w));
    r.py = 32'(blend_toward(ra.py, rb.py, w));
    r.pz = 32'(blend_toward(ra.pz, rb.pz, w));
    r.nx = 16'(blend_toward(ra.nx, rb.nx, w));
    r.ny = 16'(blend_toward(ra.ny, rb.ny, w));
    r.nz = 16'(blend_toward(ra.nz, rb.nz, w));
    return r;
  endfunction

  function automatic void store_word(vtx_item_t it);
    bit full;
    if (it.widx >= WORDS_PER_BONE) return;
    bone_words[it.bone_a][it.widx] = it.wval;
    if (!word_loaded[it.bone_a][it.widx]) begin
      word_loaded[it.bone_a][it.widx] = 1'b1;
      full = 1'b1;
      for (int k = 0; k < WORDS_PER_BONE; k++) full &= word_loaded[it.bone_a][k];
      if (full) loaded_bones.push_back(it.bone_a);
    end
  endfunction

  task automatic send_item(vtx_item_t it, bit typed, skinned_t res);
    in_valid_i <= 1'b1;
    action_i <= it.action;
    bone_a_i <= it.bone_a;
    bone_b_i <= it.bone_b;
    weight_a_i <= it.weight;
    pos_x_i <= it.px; pos_y_i <= it.py; pos_z_i <= it.pz;
    norm_x_i <= it.nx; norm_y_i <= it.ny; norm_z_i <= it.nz;
    word_index_i <= it.widx;
    word_value_i <= it.wval;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.action) store_word(it);
    else skinned_q.push_back(typed ? res : skin_vertex(it));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (skinned_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_margin(logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    snap_margin = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic word_t rand_matrix_word();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $signed($urandom_range(0, 262143)) - 131072;
      default: return $urandom_range(0, 1) ? 32'sd65536 : 32'sd0;
    endcase
  endfunction

  function automatic vtx_item_t load_item(int b, int k, word_t v);
    vtx_item_t it;
    it = '{default: '0};
    it.action = 1'b1;
    it.bone_a = 9'(b);
    it.bone_b = 9'($urandom);
    it.weight = 17'($urandom);
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.nx = 16'($urandom); it.ny = 16'($urandom); it.nz = 16'($urandom);
    it.widx = 4'(k);
    it.wval = v;
    return it;
  endfunction

  function automatic vtx_item_t vertex_item(int ba, int bb, int w, word_t p, half_t n);
    vtx_item_t it;
    it = '{default: '0};
    it.bone_a = 9'(ba);
    it.bone_b = 9'(bb);
    it.weight = 17'(w);
    it.px = p; it.py = p; it.pz = p;
    it.nx = n; it.ny = n; it.nz = n;
    it.widx = 4'($urandom);
    it.wval = $urandom;
    return it;
  endfunction

  function automatic vtx_item_t random_item();
    vtx_item_t it;
    int sel;
    if ($urandom_range(0, 99) < 30 || loaded_bones.size() == 0) begin
      it = load_item(bone_pool[$urandom_range(0, bone_pool.size() - 1)],
                     ($urandom_range(0, 7) == 0) ? $urandom_range(12, 15)
                                                 : $urandom_range(0, 11),
                     rand_matrix_word());
      return it;
    end
    it = vertex_item(loaded_bones[$urandom_range(0, loaded_bones.size() - 1)],
                     loaded_bones[$urandom_range(0, loaded_bones.size() - 1)],
                     0, 0, 0);
    sel = $urandom_range(0, 5);
    case (sel)
      0: it.weight = 17'($urandom_range(0, 131071));
      1: it.weight = 17'(snap_margin + $urandom_range(0, 2) - 1);
      2: it.weight = 17'(65536 - snap_margin + $urandom_range(0, 2) - 1);
      default: it.weight = 17'($urandom_range(0, 65536));
    endcase
    if ($urandom_range(0, 1)) begin
      it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    end else begin
      it.px = $signed($urandom_range(0, 2097151)) - 1048576;
      it.py = $signed($urandom_range(0, 2097151)) - 1048576;
      it.pz = $signed($urandom_range(0, 2097151)) - 1048576;
    end
    it.nx = 16'($urandom); it.ny = 16'($urandom); it.nz = 16'($urandom);
    return it;
  endfunction

  always @(posedge clk_i) begin
    skinned_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = '{out_pos_x_o, out_pos_y_o, out_pos_z_o, out_norm_x_o, out_norm_y_o,
              out_norm_z_o};
      if (skinned_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", got);
      end else begin
        want = skinned_q.pop_front();
        if (!same_result(got, want)) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)
        || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    row_t rows [$];
    skinned_t none, hi_res, lo_res;
    word_t p;
    half_t n;
    int send_pct [4];
    int recv_pct [4];
    logic [15:0] margins [4];
    none = '{default: '0};
    hi_res = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF,
               16'sh7FFF};
    lo_res = '{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -16'sh8000,
               -16'sh8000, -16'sh8000};
    bone_pool = '{0, 1, 2, 3, 170, 341, 510, 511};
    repeat (6) bone_pool.push_back($urandom_range(4, 509));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bone 0 is the identity, bone 1 is all maximum words, bone 511 is random.
    for (int k = 0; k < WORDS_PER_BONE; k++) begin
      send_item(load_item(0, k, (k % 4 == 0 && k < 9) ? 32'sd65536 : 32'sd0), 1'b0, none);
      send_item(load_item(1, k, 32'sh7FFF_FFFF), 1'b0, none);
      send_item(load_item(511, k, rand_matrix_word()), 1'b0, none);
    end

    for (int i = 0; i < 4; i++) begin
      p = (i == 0) ? 32'sh7FFF_FFFF : (i == 1) ? -32'sh8000_0000 : $urandom;
      n = (i == 0) ? 16'sh7FFF : (i == 1) ? -16'sh8000 : 16'($urandom);
      rows.push_back('{vertex_item(0, 1, 65536, p, n), 1'b1, '{p, p, p, n, n, n}});
      rows.push_back('{vertex_item(1, 0, 0, p, n), 1'b1, '{p, p, p, n, n, n}});
    end
    rows.push_back('{vertex_item(1, 0, 65536, 32'sh7FFF_FFFF, 16'sh7FFF), 1'b1, hi_res});
    rows.push_back('{vertex_item(1, 0, 131071, -32'sh8000_0000, -16'sh8000), 1'b1, lo_res});
    rows.push_back('{vertex_item(0, 1, 65470, $urandom, 16'($urandom)), 1'b0, none});
    rows.push_back('{vertex_item(0, 1, 65469, $urandom, 16'($urandom)), 1'b0, none});
    rows.push_back('{vertex_item(511, 0, 66, $urandom, 16'($urandom)), 1'b0, none});
    rows.push_back('{vertex_item(511, 0, 67, $urandom, 16'($urandom)), 1'b0, none});
    rows.push_back('{vertex_item(511, 1, 32768, $urandom, 16'($urandom)), 1'b0, none});
    rows.push_back('{load_item(0, 12, 32'sh1234_5678), 1'b0, none});
    rows.push_back('{load_item(0, 15, -32'sh1), 1'b0, none});
    rows.push_back('{vertex_item(0, 0, 65536, 32'sh0001_0000, 16'sh4000), 1'b1,
                     '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 16'sh4000,
                       16'sh4000, 16'sh4000}});
    rows.push_back('{load_item(511, 9, 32'sh7FFF_FFFF), 1'b0, none});
    rows.push_back('{vertex_item(511, 511, 40000, $urandom, 16'($urandom)), 1'b0, none});
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);

    margins = '{16'd32768, 16'd0, 16'($urandom_range(1, 32767)), MARGIN_RESET};
    send_pct = '{0, 58, 0, 33};
    recv_pct = '{0, 0, 58, 33};
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      write_margin(margins[ph]);
      stall_pct = recv_pct[ph];
      for (int i = 0; i < 150; i++) begin
        send_item(random_item(), 1'b0, none);
        if ($urandom_range(0, 99) < send_pct[ph]) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
